FILE: rtl/core/gnce_pkg.sv
// Shared constants, register codes and slot decode for the grid neighbor cell enumerator.
// No dependencies; imported by grid_neighbor_cell_enumerator_core.
package gnce_pkg;

  // Field widths
  localparam int POS_W     = 24;
  localparam int EXT_W     = 23;
  localparam int CNT_W     = 7;
  localparam int IDX_W     = 18;
  localparam int SLOT_W    = 5;
  localparam int CFG_IDX_W = 3;

  // Neighborhood constants
  localparam int SLOT_COUNT = 27;
  localparam logic [SLOT_W-1:0] LAST_SLOT   = SLOT_W'(SLOT_COUNT - 1);
  localparam logic [SLOT_W-1:0] CENTER_SLOT = SLOT_W'((SLOT_COUNT - 1) / 2);

  // Default grid limit per axis
  localparam int MAX_CELLS_DEF = 64;

  // Register reset values
  localparam logic [EXT_W-1:0] HALF_EXT_RST  = EXT_W'(65536);
  localparam logic [EXT_W-1:0] CELL_EDGE_RST = EXT_W'(8192);
  localparam logic [CNT_W-1:0] CELLS_RST     = CNT_W'(16);

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_X    = 3'd0,
    REG_HALF_Y    = 3'd1,
    REG_HALF_Z    = 3'd2,
    REG_CELL_EDGE = 3'd3,
    REG_CELLS_X   = 3'd4,
    REG_CELLS_Y   = 3'd5,
    REG_CELLS_Z   = 3'd6
  } cfg_reg_t;

  // Per-axis neighbor offsets, each -1, 0 or +1
  typedef struct packed {
    logic signed [1:0] x;
    logic signed [1:0] y;
    logic signed [1:0] z;
  } ofs_t;

  // Decode a slot number into offsets: x outer, y middle, z inner
  function automatic ofs_t slot_offset(input logic [SLOT_W-1:0] slot);
    logic [1:0]        d9;
    logic [1:0]        d3;
    logic [SLOT_W-1:0] r9;
    logic [SLOT_W-1:0] r3;
    ofs_t              o;
    d9 = (slot >= SLOT_W'(18)) ? 2'd2 : ((slot >= SLOT_W'(9)) ? 2'd1 : 2'd0);
    r9 = slot - SLOT_W'(SLOT_W'(d9) * SLOT_W'(9));
    d3 = (r9 >= SLOT_W'(6)) ? 2'd2 : ((r9 >= SLOT_W'(3)) ? 2'd1 : 2'd0);
    r3 = r9 - SLOT_W'(SLOT_W'(d3) * SLOT_W'(3));
    o.x = d9 - 2'd1;
    o.y = d3 - 2'd1;
    o.z = r3[1:0] - 2'd1;
    return o;
  endfunction

endpackage

FILE: rtl/core/grid_neighbor_cell_enumerator_core.sv
// Grid neighbor cell enumerator: home cell search and 3x3x3 neighbor cell stream.
// Depends on gnce_pkg for widths, register codes and the slot decode.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | in        | in_valid/in_stall  | in_pos_x, in_pos_y, in_pos_z
//  out     | out       | out_valid/out_stall| slot, cell, home, mirror, offsets, last
//  cfg     | in        | cfg_we             | cfg_idx, cfg_wdata
//
// One position gives 27 beats, one per cycle unless out stalls; the emitter takes a new position
// only once its last slot moves on, so the single-beat-per-cycle emitter sets the position rate.
// The first beat passes through log2(MAX_CELLS_PER_AXIS) + 7 registers after the position is
// taken: an input stage, one stage per quotient bit, clamp, emitter and four index stages.
// The next position enters the divider while the previous one is still being emitted.
// Reset is synchronous and clears valid bits and configuration registers; no clearing pass.
// A stall on out holds every full stage behind it while empty stages still fill;
// nothing is dropped or repeated.
module grid_neighbor_cell_enumerator_core
  import gnce_pkg::*;
#(
  parameter int MAX_CELLS_PER_AXIS = MAX_CELLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [POS_W-1:0]     in_pos_x,
  input  logic [POS_W-1:0]     in_pos_y,
  input  logic [POS_W-1:0]     in_pos_z,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SLOT_W-1:0]    out_neighbor_slot,
  output logic [IDX_W-1:0]     out_cell_index,
  output logic [IDX_W-1:0]     out_home_cell,
  output logic                 out_is_mirror,
  output logic signed [1:0]    out_offset_x,
  output logic signed [1:0]    out_offset_y,
  output logic signed [1:0]    out_offset_z,
  output logic                 out_last_slot,
  // configuration port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [EXT_W-1:0]     cfg_wdata
);

  // Derived widths
  localparam int QW   = (MAX_CELLS_PER_AXIS > 1) ? $clog2(MAX_CELLS_PER_AXIS) : 1;
  localparam int NW   = $clog2(MAX_CELLS_PER_AXIS + 1);
  localparam int CMW  = (NW > CNT_W) ? NW : CNT_W;
  localparam int SUMW = POS_W + 2;
  localparam int RW   = SUMW - 1;
  localparam int DW   = RW + QW;
  localparam int CPW  = NW + QW;
  localparam int VW   = QW + 2;
  localparam int PW   = QW + 2 * NW + 1;
  localparam int FW   = (PW > IDX_W) ? PW : IDX_W;

  typedef struct packed {
    logic [2:0]         neg;
    logic [2:0]         ovf;
    logic [2:0][RW-1:0] rem;
    logic [2:0][QW-1:0] quo;
  } div_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    ofs_t               ofs;
    logic               mir;
    logic [2:0][QW-1:0] m;
    logic [2:0][QW-1:0] c;
  } e1_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    ofs_t              ofs;
    logic              mir;
    logic [PW-1:0]     pa;
    logic [PW-1:0]     ph;
    logic [QW-1:0]     my;
    logic [QW-1:0]     cy;
    logic [QW-1:0]     mz;
    logic [QW-1:0]     cz;
  } e2_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    ofs_t              ofs;
    logic              mir;
    logic [PW-1:0]     pb;
    logic [PW-1:0]     hb;
    logic [QW-1:0]     mz;
    logic [QW-1:0]     cz;
  } e3_t;

  // Clamp a raw cell count to 1..MAX_CELLS_PER_AXIS
  function automatic logic [NW-1:0] eff_cnt(input logic [CNT_W-1:0] c);
    logic [CMW-1:0] e;
    e = CMW'(c);
    if (e == '0) return NW'(1);
    if (e > CMW'(MAX_CELLS_PER_AXIS)) return NW'(MAX_CELLS_PER_AXIS);
    return NW'(e);
  endfunction

  // Configuration registers
  logic [EXT_W-1:0] half_x_r, half_y_r, half_z_r, cell_edge_r;
  logic [CNT_W-1:0] cnt_x_r, cnt_y_r, cnt_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_x_r    <= HALF_EXT_RST;
      half_y_r    <= HALF_EXT_RST;
      half_z_r    <= HALF_EXT_RST;
      cell_edge_r <= CELL_EDGE_RST;
      cnt_x_r     <= CELLS_RST;
      cnt_y_r     <= CELLS_RST;
      cnt_z_r     <= CELLS_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_HALF_X:    half_x_r    <= cfg_wdata;
        REG_HALF_Y:    half_y_r    <= cfg_wdata;
        REG_HALF_Z:    half_z_r    <= cfg_wdata;
        REG_CELL_EDGE: cell_edge_r <= cfg_wdata;
        REG_CELLS_X:   cnt_x_r     <= cfg_wdata[CNT_W-1:0];
        REG_CELLS_Y:   cnt_y_r     <= cfg_wdata[CNT_W-1:0];
        REG_CELLS_Z:   cnt_z_r     <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective grid settings; the user must change the registers only while idle (not enforced here)
  logic [EXT_W-1:0]         edge_eff;
  logic [2:0][NW-1:0]       n_eff;
  logic [2:0][EXT_W-1:0]    half;
  logic [2:0][POS_W-1:0]    pos;

  assign edge_eff = (cell_edge_r == '0) ? EXT_W'(1) : cell_edge_r;
  assign n_eff[0] = eff_cnt(cnt_x_r);
  assign n_eff[1] = eff_cnt(cnt_y_r);
  assign n_eff[2] = eff_cnt(cnt_z_r);
  assign half[0]  = half_x_r;
  assign half[1]  = half_y_r;
  assign half[2]  = half_z_r;
  assign pos[0]   = in_pos_x;
  assign pos[1]   = in_pos_y;
  assign pos[2]   = in_pos_z;

  // Pipeline registers and ready chain
  div_t              div_r [QW+1];
  div_t              div_nxt [QW+1];
  logic [QW:0]       dv_r;
  logic [QW:0]       up_v;
  logic [QW:0]       rdy_d;
  logic [2:0][QW-1:0] cl_c_r, cl_c_nxt;
  logic              cl_v_r;
  logic [2:0][QW-1:0] em_c_r;
  logic              em_v_r;
  logic [SLOT_W-1:0] sl_r;
  e1_t               e1_r, e1_nxt;
  e2_t               e2_r, e2_nxt;
  e3_t               e3_r, e3_nxt;
  logic              e1_v_r, e2_v_r, e3_v_r, o_v_r;
  logic              rdy_o, rdy_e3, rdy_e2, rdy_e1, rdy_cl, em_take;
  logic [FW-1:0]     cell_nxt, home_nxt;

  // Back-pressure: a stage loads when empty or when its successor moves
  always_comb begin
    rdy_o   = !o_v_r  || !out_stall;
    rdy_e3  = !e3_v_r || rdy_o;
    rdy_e2  = !e2_v_r || rdy_e3;
    rdy_e1  = !e1_v_r || rdy_e2;
    em_take = !em_v_r || (rdy_e1 && (sl_r == LAST_SLOT));
    rdy_cl  = !cl_v_r || em_take;
    rdy_d[QW] = !dv_r[QW] || rdy_cl;
    for (int j = QW - 1; j >= 0; j--) begin
      rdy_d[j] = !dv_r[j] || rdy_d[j+1];
    end
  end

  assign in_stall = !rdy_d[0];

  always_comb begin
    up_v[0] = in_valid;
    for (int j = 1; j <= QW; j++) begin
      up_v[j] = dv_r[j-1];
    end
  end

  // Offset each axis by the half extent and flag negative sums and quotient overflow,
  // then restoring division, one quotient bit per stage, most significant first
  always_comb begin
    logic [SUMW-1:0] sum;
    logic [DW-1:0]   trial;
    logic [DW-1:0]   r;
    div_nxt[0] = '0;
    for (int a = 0; a < 3; a++) begin
      sum = {{2{pos[a][POS_W-1]}}, pos[a]} + SUMW'(half[a]);
      div_nxt[0].neg[a] = sum[SUMW-1];
      div_nxt[0].rem[a] = sum[RW-1:0];
      div_nxt[0].ovf[a] = (DW'(sum[RW-1:0]) >= (DW'(edge_eff) << QW));
    end
    for (int j = 0; j < QW; j++) begin
      div_nxt[j+1] = div_r[j];
      for (int a = 0; a < 3; a++) begin
        trial = DW'(edge_eff) << (QW - 1 - j);
        r     = DW'(div_r[j].rem[a]);
        if (r >= trial) begin
          div_nxt[j+1].rem[a]           = RW'(r - trial);
          div_nxt[j+1].quo[a][QW-1-j]   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j <= QW; j++) begin
      if (!rst_n) begin
        dv_r[j] <= 1'b0;
      end else if (rdy_d[j]) begin
        dv_r[j] <= up_v[j];
      end
      if (rdy_d[j]) begin
        div_r[j] <= div_nxt[j];
      end
    end
  end

  // Clamp the home cell to 0..N-1 per axis
  always_comb begin
    logic [NW-1:0] nm1;
    for (int a = 0; a < 3; a++) begin
      nm1 = n_eff[a] - NW'(1);
      if (div_r[QW].neg[a]) begin
        cl_c_nxt[a] = '0;
      end else if (div_r[QW].ovf[a] ||
                   (CPW'(div_r[QW].quo[a]) > CPW'(nm1))) begin
        cl_c_nxt[a] = QW'(nm1);
      end else begin
        cl_c_nxt[a] = div_r[QW].quo[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cl_v_r <= 1'b0;
    end else if (rdy_cl) begin
      cl_v_r <= dv_r[QW];
    end
    if (rdy_cl) begin
      cl_c_r <= cl_c_nxt;
    end
  end

  // Emitter: hold one home cell and step through the 27 slots
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_v_r <= 1'b0;
      sl_r   <= '0;
    end else if (em_take) begin
      em_v_r <= cl_v_r;
      sl_r   <= '0;
    end else if (rdy_e1) begin
      sl_r   <= sl_r + SLOT_W'(1);
    end
    if (em_take) begin
      em_c_r <= cl_c_r;
    end
  end

  // Clamp each neighbor coordinate back into the grid and flag the beat as a mirror
  always_comb begin
    logic signed [VW-1:0] v;
    logic signed [1:0]    o;
    e1_nxt      = '0;
    e1_nxt.slot = sl_r;
    e1_nxt.ofs  = slot_offset(sl_r);
    e1_nxt.c    = em_c_r;
    for (int a = 0; a < 3; a++) begin
      o = (a == 0) ? e1_nxt.ofs.x : ((a == 1) ? e1_nxt.ofs.y : e1_nxt.ofs.z);
      v = $signed({2'b00, em_c_r[a]}) + VW'(o);
      if (v < 0) begin
        e1_nxt.m[a] = '0;
        e1_nxt.mir  = 1'b1;
      end else if (VW'(v) >= VW'(n_eff[a])) begin
        e1_nxt.m[a] = QW'(n_eff[a] - NW'(1));
        e1_nxt.mir  = 1'b1;
      end else begin
        e1_nxt.m[a] = QW'(v);
      end
    end
  end

  // First product: x times Y for the neighbor and the home cell
  always_comb begin
    e2_nxt      = '0;
    e2_nxt.slot = e1_r.slot;
    e2_nxt.ofs  = e1_r.ofs;
    e2_nxt.mir  = e1_r.mir;
    e2_nxt.pa   = PW'(e1_r.m[0]) * PW'(n_eff[1]);
    e2_nxt.ph   = PW'(e1_r.c[0]) * PW'(n_eff[1]);
    e2_nxt.my   = e1_r.m[1];
    e2_nxt.cy   = e1_r.c[1];
    e2_nxt.mz   = e1_r.m[2];
    e2_nxt.cz   = e1_r.c[2];
  end

  // Second product: (x*Y + y) times Z
  always_comb begin
    e3_nxt      = '0;
    e3_nxt.slot = e2_r.slot;
    e3_nxt.ofs  = e2_r.ofs;
    e3_nxt.mir  = e2_r.mir;
    e3_nxt.pb   = PW'(e2_r.pa + PW'(e2_r.my)) * PW'(n_eff[2]);
    e3_nxt.hb   = PW'(e2_r.ph + PW'(e2_r.cy)) * PW'(n_eff[2]);
    e3_nxt.mz   = e2_r.mz;
    e3_nxt.cz   = e2_r.cz;
  end

  // Final add of z
  assign cell_nxt = FW'(e3_r.pb + PW'(e3_r.mz));
  assign home_nxt = FW'(e3_r.hb + PW'(e3_r.cz));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r <= 1'b0;
      e2_v_r <= 1'b0;
      e3_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (rdy_e1) e1_v_r <= em_v_r;
      if (rdy_e2) e2_v_r <= e1_v_r;
      if (rdy_e3) e3_v_r <= e2_v_r;
      if (rdy_o)  o_v_r  <= e3_v_r;
    end
    if (rdy_e1) e1_r <= e1_nxt;
    if (rdy_e2) e2_r <= e2_nxt;
    if (rdy_e3) e3_r <= e3_nxt;
    if (rdy_o) begin
      out_neighbor_slot <= e3_r.slot;
      out_cell_index    <= cell_nxt[IDX_W-1:0];
      out_home_cell     <= home_nxt[IDX_W-1:0];
      out_is_mirror     <= e3_r.mir;
      out_offset_x      <= e3_r.ofs.x;
      out_offset_y      <= e3_r.ofs.y;
      out_offset_z      <= e3_r.ofs.z;
      out_last_slot     <= (e3_r.slot == LAST_SLOT);
    end
  end

  assign out_valid = o_v_r;

  // Checks on the enumeration
  a_last_flag : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_slot == (out_neighbor_slot == LAST_SLOT)))
    else $error("last_slot flag disagrees with slot number");

  a_center_home : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_neighbor_slot == CENTER_SLOT)) |->
      (!out_is_mirror && (out_cell_index == out_home_cell)))
    else $error("center neighbor is not the home cell");

  a_slot_range : assert property (@(posedge clk) disable iff (!rst_n)
    em_v_r |-> (sl_r <= LAST_SLOT))
    else $error("emitter slot counter ran past the last slot");

  a_offsets : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({out_offset_x, out_offset_y, out_offset_z} ==
                   slot_offset(out_neighbor_slot)))
    else $error("offsets disagree with slot number");

endmodule
